>>> hdl/tnlc_pkg.sv
// ============================================================================
// TDMA node link controller package
// Shared request and response payload types, event codes and link phases.
// ============================================================================
package tnlc_pkg;

   // Event codes carried in the request opcode field.
   typedef enum logic [2:0] {
      OP_FRAME_END     = 3'd0,
      OP_SYNC_WORD     = 3'd1,
      OP_BEACON_ALARM  = 3'd2,
      OP_TIMEOUT_ALARM = 3'd3,
      OP_SEND_REQUEST  = 3'd4
   } opcode_type;

   // Link phases.
   typedef enum logic [1:0] {
      PH_SEARCH   = 2'd0,
      PH_BACKOFF  = 2'd1,
      PH_WAIT_RX  = 2'd2,
      PH_ATTACHED = 2'd3
   } phase_type;

   // Radio commands.
   localparam logic [1:0] RC_NONE = 2'd0;
   localparam logic [1:0] RC_RX   = 2'd1;
   localparam logic [1:0] RC_PWD  = 2'd2;

   // Kinds of transmit scheduled by the send alarm.
   localparam logic SEND_ATTACH = 1'b0;
   localparam logic SEND_DATA   = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NODE_ADDRESS    = 3'd0;
   localparam logic [2:0] CSR_BEACON_PERIOD   = 3'd1;
   localparam logic [2:0] CSR_SAFETY_MARGIN   = 3'd2;
   localparam logic [2:0] CSR_SLOT_LENGTH     = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_WINDOW  = 3'd4;
   localparam logic [2:0] CSR_MAX_MISSED      = 3'd5;
   localparam logic [2:0] CSR_CONTROL_SLOT    = 3'd6;
   localparam logic [2:0] CSR_BEACON_OVERHEAD = 3'd7;

   // Slot value meaning no slot granted.
   localparam logic [7:0] NO_SLOT      = 8'hFF;
   // Saturation limit of the missed-beacon counter.
   localparam logic [7:0] MISSED_LIMIT = 8'hFF;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] timestamp;
      logic        crc_ok;
      logic [7:0]  fifo_count;
      logic [7:0]  header_length;
      logic        is_beacon;
      logic [7:0]  sender_address;
      logic        attach_ok;
      logic [7:0]  control_target;
      logic [7:0]  granted_slot;
      logic [3:0]  random_nibble;
   } req_type;

   typedef struct packed {
      logic [1:0]  link_state;
      logic [1:0]  radio_command;
      logic        beacon_alarm_set;
      logic [15:0] beacon_alarm_time;
      logic        timeout_alarm_set;
      logic [15:0] timeout_alarm_time;
      logic        cancel_timeout;
      logic        send_alarm_set;
      logic [15:0] send_alarm_time;
      logic        send_kind;
      logic [7:0]  assigned_slot;
      logic [7:0]  coordinator;
   } rsp_type;

endpackage

>>> hdl/tdma_node_link_controller.sv
// ============================================================================
// TDMA node link controller
// Event-driven link layer of a TDMA node: beacon search, attach backoff,
// attach reply handling, beacon tracking with missed-beacon recovery and
// scheduling of queued data in the granted slot.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  ---------------------------
//   req_      in         req_valid / req_stall   tnlc_pkg::req_type
//   rsp_      out        rsp_valid / rsp_stall   tnlc_pkg::rsp_type
//   csr_      in         csr_wr_en               csr_index, csr_wdata
//
// Every request produces exactly one response. A request is captured in an
// input register, decoded by one pass of shallow logic and its response lands
// in the output register; the sustained rate is one request per cycle unless
// rsp_stall holds it; the 16 x 8 alarm multipliers in the decode pass set
// the clock limit. Reset is synchronous and active high; it clears the link
// state and loads the register defaults. A stall on the response side holds
// the output register, then the input register, and only then stalls requests.
//
module tdma_node_link_controller #(
   parameter int BEACON_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tnlc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tnlc_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   // Expected byte count and header length byte of a well-formed beacon.
   localparam logic [7:0] BEACON_COUNT   = 8'(BEACON_BYTES);
   localparam logic [7:0] BEACON_HDR_LEN = 8'(BEACON_BYTES - 1);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [7:0]  node_address_ff;
   logic [15:0] beacon_period_ff;
   logic [15:0] safety_margin_ff;
   logic [15:0] slot_length_ff;
   logic [15:0] timeout_window_ff;
   logic [7:0]  max_missed_ff;
   logic [7:0]  control_slot_ff;
   logic [15:0] beacon_overhead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff    <= 8'd0;
         beacon_period_ff   <= 16'd32768;
         safety_margin_ff   <= 16'd64;
         slot_length_ff     <= 16'd256;
         timeout_window_ff  <= 16'd256;
         max_missed_ff      <= 8'd4;
         control_slot_ff    <= 8'd1;
         beacon_overhead_ff <= 16'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            tnlc_pkg::CSR_NODE_ADDRESS:    node_address_ff    <= csr_wdata[7:0];
            tnlc_pkg::CSR_BEACON_PERIOD:   beacon_period_ff   <= csr_wdata;
            tnlc_pkg::CSR_SAFETY_MARGIN:   safety_margin_ff   <= csr_wdata;
            tnlc_pkg::CSR_SLOT_LENGTH:     slot_length_ff     <= csr_wdata;
            tnlc_pkg::CSR_TIMEOUT_WINDOW:  timeout_window_ff  <= csr_wdata;
            tnlc_pkg::CSR_MAX_MISSED:      max_missed_ff      <= csr_wdata[7:0];
            tnlc_pkg::CSR_CONTROL_SLOT:    control_slot_ff    <= csr_wdata[7:0];
            tnlc_pkg::CSR_BEACON_OVERHEAD: beacon_overhead_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. The decode stage hands its request to the output
   // register whenever that register is empty or being drained.
   // ------------------------------------------------------------------
   logic              req_valid_ff;
   tnlc_pkg::req_type req_ff;
   logic              rsp_valid_ff;
   tnlc_pkg::rsp_type rsp_ff;
   tnlc_pkg::rsp_type rsp_in;

   logic rsp_load;
   logic req_load;

   assign rsp_load  = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !rsp_load;
   assign req_load  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_load || rsp_load) begin
         req_valid_ff <= req_load;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Link state. It changes only when the decoded request moves on to the
   // output register, so the next request always sees its effect.
   // ------------------------------------------------------------------
   tnlc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  coordinator_ff, coordinator_in;
   logic [7:0]  slot_ff, slot_in;
   logic [4:0]  backoff_ff, backoff_in;
   logic [7:0]  missed_ff, missed_in;
   logic [15:0] last_sync_ff, last_sync_in;
   logic [15:0] beacon_start_ff, beacon_start_in;
   logic        data_pending_ff, data_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tnlc_pkg::PH_SEARCH;
         coordinator_ff  <= 8'd0;
         slot_ff         <= tnlc_pkg::NO_SLOT;
         backoff_ff      <= 5'd0;
         missed_ff       <= 8'd0;
         last_sync_ff    <= 16'd0;
         beacon_start_ff <= 16'd0;
         data_pending_ff <= 1'b0;
      end else if (rsp_load) begin
         phase_ff        <= phase_in;
         coordinator_ff  <= coordinator_in;
         slot_ff         <= slot_in;
         backoff_ff      <= backoff_in;
         missed_ff       <= missed_in;
         last_sync_ff    <= last_sync_in;
         beacon_start_ff <= beacon_start_in;
         data_pending_ff <= data_pending_in;
      end
   end

   // ------------------------------------------------------------------
   // Arithmetic shared by the event handlers.
   // ------------------------------------------------------------------
   // A frame's transmit slot: the control slot while backing off, else the
   // granted slot. Only the low 16 bits of the product matter (ticks wrap).
   logic [7:0]  slot_sel;
   logic [23:0] slot_prod;
   logic [15:0] frame_start;

   assign slot_sel    = (phase_ff == tnlc_pkg::PH_BACKOFF) ? control_slot_ff : slot_ff;
   assign slot_prod   = 24'(slot_sel) * 24'(slot_length_ff);
   assign frame_start = last_sync_ff - beacon_overhead_ff;

   // After a miss the wake-up moves out by n periods, each one safety margin
   // earlier: start + n * (period - margin), with n one past the new count.
   logic [7:0]  missed_inc;
   logic [7:0]  miss_periods;
   logic [15:0] period_delta;
   logic [23:0] miss_prod;
   logic        frame_ok;

   assign missed_inc   = (missed_ff < tnlc_pkg::MISSED_LIMIT) ? missed_ff + 8'd1 : missed_ff;
   assign miss_periods = missed_inc + 8'd1;
   assign period_delta = beacon_period_ff - safety_margin_ff;
   assign miss_prod    = 24'(period_delta) * 24'(miss_periods);

   assign frame_ok = req_ff.crc_ok && req_ff.is_beacon &&
                     (req_ff.fifo_count == BEACON_COUNT) &&
                     (req_ff.header_length == BEACON_HDR_LEN);

   // ------------------------------------------------------------------
   // Event decode.
   // ------------------------------------------------------------------
   always_comb begin
      phase_in        = phase_ff;
      coordinator_in  = coordinator_ff;
      slot_in         = slot_ff;
      backoff_in      = backoff_ff;
      missed_in       = missed_ff;
      last_sync_in    = last_sync_ff;
      beacon_start_in = beacon_start_ff;
      data_pending_in = data_pending_ff;
      rsp_in          = '0;

      case (req_ff.opcode)
         tnlc_pkg::OP_FRAME_END: begin
            if (!frame_ok) begin
               rsp_in.radio_command = tnlc_pkg::RC_RX;
            end else begin
               rsp_in.cancel_timeout = 1'b1;
               if (phase_ff != tnlc_pkg::PH_SEARCH &&
                   req_ff.sender_address != coordinator_ff) begin
                  // A beacon from some other coordinator only cancels the timeout.
                  rsp_in.radio_command = tnlc_pkg::RC_RX;
               end else begin
                  if (phase_ff == tnlc_pkg::PH_SEARCH) begin
                     coordinator_in = req_ff.sender_address;
                  end
                  missed_in                = 8'd0;
                  beacon_start_in          = frame_start;
                  rsp_in.beacon_alarm_set  = 1'b1;
                  rsp_in.beacon_alarm_time = frame_start - safety_margin_ff +
                                             beacon_period_ff;
                  case (phase_ff)
                     tnlc_pkg::PH_SEARCH: begin
                        backoff_in = 5'd1 + 5'(req_ff.random_nibble);
                        phase_in   = tnlc_pkg::PH_BACKOFF;
                     end
                     tnlc_pkg::PH_BACKOFF: begin
                        backoff_in = backoff_ff - 5'd1;
                        if (backoff_ff == 5'd1) begin
                           rsp_in.send_alarm_set  = 1'b1;
                           rsp_in.send_alarm_time = frame_start + slot_prod[15:0];
                           rsp_in.send_kind       = tnlc_pkg::SEND_ATTACH;
                           phase_in               = tnlc_pkg::PH_WAIT_RX;
                        end
                     end
                     tnlc_pkg::PH_WAIT_RX: begin
                        if (req_ff.attach_ok && req_ff.control_target == node_address_ff) begin
                           slot_in  = req_ff.granted_slot;
                           phase_in = tnlc_pkg::PH_ATTACHED;
                        end else begin
                           phase_in = tnlc_pkg::PH_SEARCH;
                        end
                     end
                     default: begin
                        if (data_pending_ff) begin
                           rsp_in.send_alarm_set  = 1'b1;
                           rsp_in.send_alarm_time = frame_start + slot_prod[15:0];
                           rsp_in.send_kind       = tnlc_pkg::SEND_DATA;
                           data_pending_in        = 1'b0;
                        end
                     end
                  endcase
               end
            end
         end
         tnlc_pkg::OP_SYNC_WORD: begin
            last_sync_in = req_ff.timestamp;
         end
         tnlc_pkg::OP_BEACON_ALARM: begin
            rsp_in.radio_command      = tnlc_pkg::RC_RX;
            rsp_in.timeout_alarm_set  = 1'b1;
            rsp_in.timeout_alarm_time = req_ff.timestamp + timeout_window_ff;
         end
         tnlc_pkg::OP_TIMEOUT_ALARM: begin
            missed_in = missed_inc;
            if (missed_inc >= max_missed_ff) begin
               // Too many misses: drop back to search and keep listening.
               rsp_in.radio_command = tnlc_pkg::RC_RX;
               phase_in             = tnlc_pkg::PH_SEARCH;
            end else begin
               rsp_in.radio_command     = tnlc_pkg::RC_PWD;
               rsp_in.beacon_alarm_set  = 1'b1;
               rsp_in.beacon_alarm_time = beacon_start_ff + miss_prod[15:0];
            end
         end
         tnlc_pkg::OP_SEND_REQUEST: begin
            data_pending_in = 1'b1;
         end
         default: begin
         end
      endcase

      rsp_in.link_state    = phase_in;
      rsp_in.assigned_slot = slot_in;
      rsp_in.coordinator   = coordinator_in;
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // A transmit is only ever scheduled on the way to or while attached.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.send_alarm_set) |->
         (rsp_data.link_state == tnlc_pkg::PH_WAIT_RX ||
          rsp_data.link_state == tnlc_pkg::PH_ATTACHED))
      else $error("send alarm armed outside wait or attached phase");

   // The beacon and timeout alarms come from different events.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.beacon_alarm_set && rsp_data.timeout_alarm_set))
      else $error("beacon and timeout alarms armed together");

   // An accepted beacon always cancels the pending timeout.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.beacon_alarm_set && rsp_data.radio_command == tnlc_pkg::RC_NONE)
         |-> rsp_data.cancel_timeout)
      else $error("beacon accepted without cancelling timeout");

   // Requests are held off only while the decode register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff)
      else $error("request stalled with empty decode register");

   // The state registers never change while the response side is blocked.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(phase_ff) && $stable(missed_ff))
      else $error("link state changed under a stalled response");

endmodule
